@@ rtl/signal_band_hysteresis_hold_unit_macros.svh @@
// assertion macros used by the top rtl file of the signal band hysteresis hold unit
// expects clk and arst_n in the scope where a macro is used
`ifndef SIGNAL_BAND_HYSTERESIS_HOLD_UNIT_MACROS_SVH
`define SIGNAL_BAND_HYSTERESIS_HOLD_UNIT_MACROS_SVH

// condition holds on every clock edge out of reset
`define SBHH_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SBHH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ rtl/sbhh_pkg.sv @@
// types, constants and helper functions of the signal band hysteresis hold unit
// no dependencies
package sbhh_pkg;

	localparam int CHANNELS_DEF = 64;
	localparam int CH_W = 6;
	localparam int LEVEL_W = 9;
	localparam int MARGIN_W = 6;
	localparam int HOLD_W = 16;
	localparam int TIME_W = 32;
	localparam int BAND_W = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int MAX_REACH = 1 << CH_W;

	typedef logic [BAND_W-1:0] band_t;
	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam band_t BAND_MAX = 3'd4;

	localparam cfg_idx_t REG_THR_ONE = 3'd0;
	localparam cfg_idx_t REG_THR_TWO = 3'd1;
	localparam cfg_idx_t REG_THR_THREE = 3'd2;
	localparam cfg_idx_t REG_THR_FOUR = 3'd3;
	localparam cfg_idx_t REG_MARGIN = 3'd4;
	localparam cfg_idx_t REG_HOLD = 3'd5;

	typedef struct packed {
		logic [3:0][LEVEL_W-1:0] thr;
		logic [MARGIN_W-1:0] margin;
	} band_cfg_t;

	typedef struct packed {
		band_cfg_t band;
		logic [HOLD_W-1:0] hold;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		band: '{thr: {9'd168, 9'd144, 9'd120, 9'd48}, margin: 6'd6},
		hold: 16'd3000
	};

	// representative display level of each band
	function automatic level_t level_of_band(band_t b);
		level_t lv;
		unique case (b)
			3'd0: lv = 9'd0;
			3'd1: lv = 9'd80;
			3'd2: lv = 9'd132;
			3'd3: lv = 9'd156;
			default: lv = 9'd180;
		endcase
		return lv;
	endfunction

	// walk up while up[band] is set, then down while dn[band-1] is set
	function automatic band_t walk_band(band_t start, logic [3:0] up, logic [3:0] dn);
		band_t r;
		band_t rm1;
		r = start;
		for (int i = 0; i < 4; i++) begin
			if (r < BAND_MAX && up[r[1:0]])
				r = r + 3'd1;
		end
		for (int i = 0; i < 4; i++) begin
			rm1 = r - 3'd1;
			if (r != 3'd0 && r <= BAND_MAX && dn[rm1[1:0]])
				r = rm1;
		end
		return r;
	endfunction

endpackage

@@ rtl/sbhh_report_if.sv @@
// request channel carrying one signal report into the unit
// depends on sbhh_pkg
interface sbhh_report_if;
	import sbhh_pkg::*;

	logic valid;
	logic ready;
	logic [CH_W-1:0] channel;
	logic [LEVEL_W-1:0] signal_level;
	logic used_flag;
	logic [TIME_W-1:0] now_ms;

	modport source (output valid, channel, signal_level, used_flag, now_ms, input ready);
	modport sink (input valid, channel, signal_level, used_flag, now_ms, output ready);
endinterface

@@ rtl/sbhh_result_if.sv @@
// request channel carrying one display result out of the unit
// depends on sbhh_pkg
interface sbhh_result_if;
	import sbhh_pkg::*;

	logic valid;
	logic ready;
	logic [CH_W-1:0] out_channel;
	logic [BAND_W-1:0] signal_band;
	logic [LEVEL_W-1:0] display_level;
	logic display_used;

	modport source (output valid, out_channel, signal_band, display_level, display_used,
		input ready);
	modport sink (input valid, out_channel, signal_band, display_level, display_used,
		output ready);
endinterface

@@ rtl/signal_band_hysteresis_hold_unit.sv @@
// signal band hysteresis hold unit: top level with config registers and channel state
// depends on sbhh_pkg, sbhh_report_if, sbhh_result_if, sbhh_ram, sbhh_band and the macros
//
// usage
//   report (sink) takes one request per channel report: channel, signal_level,
//   used_flag, now_ms. result (source) gives one request per report, in order:
//   out_channel, signal_band (0..4), display_level and display_used.
//   cfg_we/cfg_index/cfg_wdata write the four thresholds, the margin and the hold
//   time; write only while no report is in flight.
// timing
//   a report accepted on report is held in stage 1 while the band ram and the time
//   ram do their registered read, then it loads the output register that drives result.
//   one report per cycle is sustained while result is not stalled; the rate is set by
//   the single read-modify-write pass per report through the two rams.
// stall
//   while result is stalled, the pipeline stage holds one more report and then
//   report.ready drops; no request is lost or repeated.
// reset
//   arst_n clears the per channel known and used-seen bits, empties the pipeline and
//   loads the register defaults; ram contents are only read behind those bits, so
//   no clearing pass is needed.
`include "signal_band_hysteresis_hold_unit_macros.svh"

module signal_band_hysteresis_hold_unit #(
	parameter int CHANNELS = sbhh_pkg::CHANNELS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	sbhh_report_if.sink report,
	sbhh_result_if.source result,
	input  logic cfg_we,
	input  sbhh_pkg::cfg_idx_t cfg_index,
	input  logic [sbhh_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import sbhh_pkg::*;

	// only channels that the 6 bit field can reach need storage
	localparam int DEPTH = CHANNELS < MAX_REACH ? CHANNELS : MAX_REACH;
	localparam int AW = $clog2(DEPTH > 1 ? DEPTH : 2);

	// configuration registers
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THR_ONE:   cfg_q.band.thr[0] <= cfg_wdata[LEVEL_W-1:0];
				REG_THR_TWO:   cfg_q.band.thr[1] <= cfg_wdata[LEVEL_W-1:0];
				REG_THR_THREE: cfg_q.band.thr[2] <= cfg_wdata[LEVEL_W-1:0];
				REG_THR_FOUR:  cfg_q.band.thr[3] <= cfg_wdata[LEVEL_W-1:0];
				REG_MARGIN:    cfg_q.band.margin <= cfg_wdata[MARGIN_W-1:0];
				REG_HOLD:      cfg_q.hold <= cfg_wdata[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	logic s1_valid;
	logic s1_fire;
	logic out_valid_q;
	logic accept;

	assign s1_fire = s1_valid && (!out_valid_q || result.ready);
	assign report.ready = !s1_valid || s1_fire;
	assign accept = report.valid && report.ready;

	// stage 1 holds the report while the ram reads complete
	logic [CH_W-1:0] ch_s1;
	level_t lv_s1;
	logic use_s1;
	logic [TIME_W-1:0] now_s1;
	logic inr_s1;
	logic [AW-1:0] addr_s1;
	logic [AW-1:0] rd_addr;

	assign rd_addr = AW'(report.channel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid <= 1'b0;
		else if (accept)
			s1_valid <= 1'b1;
		else if (s1_fire)
			s1_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1 <= report.channel;
			lv_s1 <= report.signal_level;
			use_s1 <= report.used_flag;
			now_s1 <= report.now_ms;
			inr_s1 <= 32'(report.channel) < CHANNELS;
			addr_s1 <= rd_addr;
		end
	end

	// per channel state: band and last use time in ram, valid bits in flops
	band_t band_rd;
	band_t band_new;
	logic [TIME_W-1:0] time_rd;
	logic band_we;
	logic time_we;
	logic [DEPTH-1:0] known_q;
	logic [DEPTH-1:0] seen_q;

	assign band_we = s1_fire && inr_s1;
	assign time_we = band_we && use_s1;

	sbhh_ram #(.WIDTH(BAND_W), .DEPTH(DEPTH)) u_band_ram (
		.clk(clk), .we(band_we), .waddr(addr_s1), .wdata(band_new),
		.re(accept), .raddr(rd_addr), .rdata(band_rd)
	);

	sbhh_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_time_ram (
		.clk(clk), .we(time_we), .waddr(addr_s1), .wdata(now_s1),
		.re(accept), .raddr(rd_addr), .rdata(time_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_q <= '0;
			seen_q <= '0;
		end else if (band_we) begin
			known_q[addr_s1] <= 1'b1;
			if (use_s1)
				seen_q[addr_s1] <= 1'b1;
		end
	end

	// forwarding of the last write, which may land on the edge of the read
	logic fwd_band_vld_q;
	logic [AW-1:0] fwd_band_addr_q;
	band_t fwd_band_q;
	logic fwd_time_vld_q;
	logic [AW-1:0] fwd_time_addr_q;
	logic [TIME_W-1:0] fwd_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_band_vld_q <= 1'b0;
			fwd_time_vld_q <= 1'b0;
		end else begin
			if (band_we)
				fwd_band_vld_q <= 1'b1;
			if (time_we)
				fwd_time_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (band_we) begin
			fwd_band_addr_q <= addr_s1;
			fwd_band_q <= band_new;
		end
		if (time_we) begin
			fwd_time_addr_q <= addr_s1;
			fwd_time_q <= now_s1;
		end
	end

	band_t stored_band;
	logic [TIME_W-1:0] last_time;
	logic known;
	logic seen;

	assign stored_band = (fwd_band_vld_q && fwd_band_addr_q == addr_s1) ? fwd_band_q : band_rd;
	assign last_time = (fwd_time_vld_q && fwd_time_addr_q == addr_s1) ? fwd_time_q : time_rd;
	assign known = inr_s1 && known_q[addr_s1];
	assign seen = inr_s1 && seen_q[addr_s1];

	sbhh_band u_band (
		.cfg(cfg_q.band), .level(lv_s1), .known(known), .stored(stored_band),
		.band(band_new)
	);

	// hold of the used mark: modular elapsed time against the hold window
	logic [TIME_W-1:0] elapsed;
	logic shown_used;

	assign elapsed = now_s1 - last_time;
	assign shown_used = use_s1 || (seen && elapsed <= {16'd0, cfg_q.hold});

	// output register
	logic [CH_W-1:0] ch_q;
	band_t band_q;
	level_t level_q;
	logic used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_fire)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			ch_q <= ch_s1;
			band_q <= band_new;
			level_q <= level_of_band(band_new);
			used_q <= shown_used;
		end
	end

	assign result.valid = out_valid_q;
	assign result.out_channel = ch_q;
	assign result.signal_band = band_q;
	assign result.display_level = level_q;
	assign result.display_used = used_q;

	`SBHH_ASSERT_IMP(a_band_range, out_valid_q, band_q <= BAND_MAX, "band out of range")
	`SBHH_ASSERT_IMP(a_level_table, out_valid_q, level_q == level_of_band(band_q), "level not of band")
	`SBHH_ASSERT_IMP(a_stall_blocks, s1_valid && !s1_fire, !report.ready, "report taken while blocked")
	`SBHH_ASSERT_IMP(a_used_shown, s1_valid && use_s1, shown_used, "used report not shown as used")
endmodule

@@ rtl/sbhh_ram.sv @@
// generic single write port ram with one registered read port
// no dependencies
module sbhh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

@@ rtl/sbhh_band.sv @@
// band decision: plain quantization or hysteresis step from the stored band
// depends on sbhh_pkg
module sbhh_band (
	input  sbhh_pkg::band_cfg_t cfg,
	input  sbhh_pkg::level_t level,
	input  logic known,
	input  sbhh_pkg::band_t stored,
	output sbhh_pkg::band_t band
);
	import sbhh_pkg::*;

	logic [3:0] ge_plain;
	logic [3:0] ge_up;
	logic [3:0] lt_dn;

	// level + margin < thr is the same as level < thr - margin without going negative
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ge_plain[i] = level >= cfg.thr[i];
			ge_up[i] = {2'b00, level} >= ({2'b00, cfg.thr[i]} + {5'd0, cfg.margin});
			lt_dn[i] = ({2'b00, level} + {5'd0, cfg.margin}) < {2'b00, cfg.thr[i]};
		end
	end

	assign band = known ? walk_band(stored, ge_up, lt_dn) : walk_band(3'd0, ge_plain, 4'd0);
endmodule

@@ tb/signal_band_hysteresis_hold_unit_test.sv @@
`timescale 1ns / 100ps
// self-checking testbench of the signal band hysteresis hold unit: directed table, then random
// reports under several register settings, each result checked against a local band predictor
// depends on sbhh_pkg, sbhh_report_if, sbhh_result_if and signal_band_hysteresis_hold_unit
module signal_band_hysteresis_hold_unit_test;
	import sbhh_pkg::*;

	// spare register indexes, writes to them must leave every setting untouched
	localparam cfg_idx_t REG_UNUSED_A = 3'd6;
	localparam cfg_idx_t REG_UNUSED_B = 3'd7;

	localparam int DUT_CHANNELS = CHANNELS_DEF;
	// settle time after draining, so that stray results can show up
	localparam int SETTLE_CYCLES = 4;
	// longest quiet stretch in a correct run is a geometric gap at 83 percent idling;
	// this is far beyond it
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PER_PHASE = 215;
	// idling schedule switches at these request counts (about a third of the run each)
	localparam int MODE_SPLIT_A = 436;
	localparam int MODE_SPLIT_B = 872;
	localparam int REPORT_LIMIT = 10;

	// representative display level per band
	localparam level_t BAND_LEVEL [5] = '{9'd0, 9'd80, 9'd132, 9'd156, 9'd180};

	typedef struct packed {
		logic [CH_W-1:0] channel;
		level_t level;
		logic used;
		logic [TIME_W-1:0] now;
	} report_t;

	typedef struct packed {
		logic [CH_W-1:0] channel;
		band_t band;
		level_t level;
		logic used;
	} display_t;

	typedef struct packed {
		report_t item;
		logic pinned;
		display_t pin;
	} directed_row_t;

	localparam display_t NO_PIN = '0;

	// directed table, reset register values (48/120/144/168, margin 6, hold 3000)
	// rows with pinned set carry a result read straight off the spec, the rest go through
	// the predictor
	localparam int DIRECTED_ROWS = 18;
	localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
		// lowest fields everywhere, first report on a channel
		'{'{6'd0, 9'd0, 1'b0, 32'd0}, 1'b1, '{6'd0, 3'd0, 9'd0, 1'b0}},
		// highest fields everywhere, plain quantize to the top band
		'{'{6'd63, 9'd511, 1'b1, 32'hFFFF_FFFF}, 1'b1, '{6'd63, 3'd4, 9'd180, 1'b1}},
		// just under the first threshold
		'{'{6'd1, 9'd47, 1'b0, 32'd5}, 1'b1, '{6'd1, 3'd0, 9'd0, 1'b0}},
		// at the threshold but inside the margin, band holds
		'{'{6'd1, 9'd48, 1'b0, 32'd6}, 1'b0, NO_PIN},
		// exactly threshold plus margin, one step up
		'{'{6'd1, 9'd54, 1'b0, 32'd7}, 1'b0, NO_PIN},
		// threshold minus margin, still holds
		'{'{6'd1, 9'd42, 1'b0, 32'd8}, 1'b0, NO_PIN},
		// one below threshold minus margin, one step down
		'{'{6'd1, 9'd41, 1'b0, 32'd9}, 1'b0, NO_PIN},
		// full walk up across every band
		'{'{6'd1, 9'd511, 1'b0, 32'd10}, 1'b0, NO_PIN},
		// full walk down
		'{'{6'd1, 9'd0, 1'b0, 32'd11}, 1'b0, NO_PIN},
		// hold: used, then exactly at the hold time, one past, then time going backwards
		'{'{6'd2, 9'd130, 1'b1, 32'd1000}, 1'b0, NO_PIN},
		'{'{6'd2, 9'd130, 1'b0, 32'd4000}, 1'b0, NO_PIN},
		'{'{6'd2, 9'd130, 1'b0, 32'd4001}, 1'b0, NO_PIN},
		'{'{6'd2, 9'd130, 1'b0, 32'd999}, 1'b0, NO_PIN},
		// hold across the wrap of the millisecond counter
		'{'{6'd3, 9'd200, 1'b1, 32'hFFFF_FF00}, 1'b0, NO_PIN},
		'{'{6'd3, 9'd200, 1'b0, 32'h0000_0100}, 1'b0, NO_PIN},
		// never used channel, level right on a threshold
		'{'{6'd4, 9'd144, 1'b0, 32'd0}, 1'b0, NO_PIN},
		// known channel jumps from the bottom to the top
		'{'{6'd0, 9'd511, 1'b0, 32'd0}, 1'b0, NO_PIN},
		// half-range time distance, hold long expired, walk down from the top
		'{'{6'd63, 9'd0, 1'b0, 32'h7FFF_FFFF}, 1'b0, NO_PIN}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	sbhh_report_if report_ch ();
	sbhh_result_if result_ch ();

	signal_band_hysteresis_hold_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.report   (report_ch),
		.result   (result_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// predictor copy of the registers and the per channel stores
	logic [LEVEL_W-1:0] thr_q [4];
	logic [MARGIN_W-1:0] margin_q;
	logic [HOLD_W-1:0] hold_q;
	band_t band_mem [DUT_CHANNELS];
	bit band_seen [DUT_CHANNELS];
	logic [TIME_W-1:0] use_stamp [DUT_CHANNELS];
	bit use_live [DUT_CHANNELS];

	// driver side record of used reports, only to aim times at the hold boundary
	logic [TIME_W-1:0] issued_use_ms [DUT_CHANNELS];
	bit issued_use [DUT_CHANNELS];
	logic [TIME_W-1:0] clock_ms;

	display_t pending_displays [$];
	int mismatch_count;
	int items_issued;
	int send_idle_pct;
	int recv_idle_pct;
	int quiet_cycles;

	// pinned result travels with the request so the checker knows which rows are typed in
	logic pinned_valid;
	display_t pinned_display;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// band and display for one report; updates the predictor stores like the block does
	function automatic display_t predict_display(report_t r);
		display_t d;
		int b;
		int lv;
		int m;
		logic shown;
		logic in_range;
		lv = int'(r.level);
		m = int'(margin_q);
		shown = r.used;
		b = 0;
		// channel field is as wide as the store, so this is always true at the default size
		in_range = int'(r.channel) < DUT_CHANNELS;
		if (in_range) begin
			if (r.used) begin
				use_stamp[r.channel] = r.now;
				use_live[r.channel] = 1'b1;
			end else if (use_live[r.channel] &&
				(r.now - use_stamp[r.channel]) <= {16'd0, hold_q}) begin
				// modular distance, so a step back in time reads as expired
				shown = 1'b1;
			end
		end
		if (in_range && band_seen[r.channel]) begin
			// hysteresis walk from the stored band: up first, then down
			b = int'(band_mem[r.channel]);
			while (b < 4 && lv >= int'(thr_q[b]) + m)
				b++;
			while (b > 0 && lv < int'(thr_q[b-1]) - m)
				b--;
		end else begin
			// plain quantize, first report on the channel
			while (b < 4 && lv >= int'(thr_q[b]))
				b++;
		end
		if (in_range) begin
			band_mem[r.channel] = band_t'(b);
			band_seen[r.channel] = 1'b1;
		end
		d.channel = r.channel;
		d.band = band_t'(b);
		d.level = BAND_LEVEL[b];
		d.used = shown;
		return d;
	endfunction

	// one request on the report channel, with a random gap ahead of it
	task automatic send_report(report_t r, logic pinned, display_t pin);
		if (items_issued < MODE_SPLIT_A) begin
			send_idle_pct = 18;
			recv_idle_pct <= 83;
		end else if (items_issued < MODE_SPLIT_B) begin
			send_idle_pct = 83;
			recv_idle_pct <= 18;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct <= 0;
		end
		while ($urandom_range(99) < send_idle_pct) begin
			report_ch.valid <= 1'b0;
			@(posedge clk);
		end
		report_ch.valid <= 1'b1;
		report_ch.channel <= r.channel;
		report_ch.signal_level <= r.level;
		report_ch.used_flag <= r.used;
		report_ch.now_ms <= r.now;
		pinned_valid <= pinned;
		pinned_display <= pin;
		items_issued++;
		@(posedge clk);
		while (!report_ch.ready)
			@(posedge clk);
	endtask

	// stop sending and wait for every expected result, then for the settle time
	task automatic drain();
		report_ch.valid <= 1'b0;
		while (pending_displays.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_THR_ONE: thr_q[0] = data[LEVEL_W-1:0];
			REG_THR_TWO: thr_q[1] = data[LEVEL_W-1:0];
			REG_THR_THREE: thr_q[2] = data[LEVEL_W-1:0];
			REG_THR_FOUR: thr_q[3] = data[LEVEL_W-1:0];
			REG_MARGIN: margin_q = data[MARGIN_W-1:0];
			REG_HOLD: hold_q = data[HOLD_W-1:0];
			default: ;
		endcase
	endtask

	// new setting of all registers, only once the block has gone idle
	// upper bits of the narrow registers carry junk that the block must drop
	task automatic configure(int t1, int t2, int t3, int t4, int marg, int hold,
		bit poke_unused);
		logic [CFG_DATA_W-1:0] junk;
		drain();
		junk = CFG_DATA_W'($urandom());
		write_register(REG_THR_ONE, {junk[15:9], 9'(t1)});
		write_register(REG_THR_TWO, {junk[15:9], 9'(t2)});
		write_register(REG_THR_THREE, {junk[15:9], 9'(t3)});
		write_register(REG_THR_FOUR, {junk[15:9], 9'(t4)});
		write_register(REG_MARGIN, {junk[15:6], 6'(marg)});
		write_register(REG_HOLD, 16'(hold));
		if (poke_unused) begin
			write_register(REG_UNUSED_A, junk);
			write_register(REG_UNUSED_B, ~junk);
		end
		cfg_we <= 1'b0;
	endtask

	// random reports: mostly a small pool of channels so the band walks build up history,
	// levels clustered around the thresholds, times aimed at the hold boundary
	task automatic run_phase(int count);
		logic [CH_W-1:0] pool [4];
		report_t r;
		int pick;
		int base;
		int span;
		for (int i = 0; i < 4; i++)
			pool[i] = CH_W'($urandom_range(63));
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 75)
				r.channel = pool[$urandom_range(3)];
			else
				r.channel = CH_W'($urandom_range(63));

			pick = $urandom_range(99);
			if (pick < 55) begin
				// within a few steps of threshold plus or minus margin
				span = int'(margin_q) + 3;
				base = int'(thr_q[$urandom_range(3)]) + int'($urandom_range(2 * span)) - span;
				if (base < 0)
					base = 0;
				if (base > 511)
					base = 511;
				r.level = level_t'(base);
			end else if (pick < 85) begin
				r.level = level_t'($urandom_range(511));
			end else begin
				r.level = $urandom_range(1) ? 9'd511 : 9'd0;
			end

			r.used = $urandom_range(99) < 35;

			pick = $urandom_range(99);
			if (pick < 5) begin
				clock_ms = $urandom();
			end else if (pick < 10) begin
				// time goes backwards
				clock_ms = clock_ms - $urandom_range(1, 5000);
			end else if (pick < 25 && issued_use[r.channel]) begin
				// right at the hold time or one past it
				clock_ms = issued_use_ms[r.channel] + hold_q + $urandom_range(1);
			end else begin
				clock_ms = clock_ms + $urandom_range(2 * int'(hold_q) + 4);
			end
			r.now = clock_ms;
			if (r.used) begin
				issued_use_ms[r.channel] = r.now;
				issued_use[r.channel] = 1'b1;
			end
			send_report(r, 1'b0, NO_PIN);
		end
	endtask

	// receiver stalls at random, rate follows the current idling schedule
	always @(posedge clk)
		result_ch.ready <= $urandom_range(99) >= recv_idle_pct;

	// predict on each accepted report, check each accepted result against the oldest one
	always @(posedge clk) begin
		display_t predicted;
		display_t want;
		display_t got;
		if (arst_n) begin
			if (report_ch.valid && report_ch.ready) begin
				predicted = predict_display('{report_ch.channel, report_ch.signal_level,
					report_ch.used_flag, report_ch.now_ms});
				pending_displays.push_back(pinned_valid ? pinned_display : predicted);
			end
			if (result_ch.valid && result_ch.ready) begin
				got = '{result_ch.out_channel, result_ch.signal_band, result_ch.display_level,
					result_ch.display_used};
				if (pending_displays.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("unexpected result: ch %0d band %0d level %0d used %0d",
							got.channel, got.band, got.level, got.used);
				end else begin
					want = pending_displays.pop_front();
					if (got.channel !== want.channel || got.band !== want.band ||
						got.level !== want.level || got.used !== want.used) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display("mismatch: expected ch %0d band %0d level %0d used %0d, %s",
								want.channel, want.band, want.level, want.used,
								$sformatf("got ch %0d band %0d level %0d used %0d",
									got.channel, got.band, got.level, got.used));
					end
				end
			end
		end
	end

	// watchdog on cycles with no request moving on either side and no register write
	always @(posedge clk) begin
		if ((report_ch.valid && report_ch.ready) || (result_ch.valid && result_ch.ready) ||
			cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		// every block input known from time zero
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_THR_ONE;
		cfg_wdata = '0;
		report_ch.valid = 1'b0;
		report_ch.channel = '0;
		report_ch.signal_level = '0;
		report_ch.used_flag = 1'b0;
		report_ch.now_ms = '0;
		result_ch.ready = 1'b0;
		pinned_valid = 1'b0;
		pinned_display = NO_PIN;
		mismatch_count = 0;
		items_issued = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		quiet_cycles = 0;
		clock_ms = '0;

		// predictor view of the reset state
		thr_q[0] = 9'd48;
		thr_q[1] = 9'd120;
		thr_q[2] = 9'd144;
		thr_q[3] = 9'd168;
		margin_q = 6'd6;
		hold_q = 16'd3000;
		for (int i = 0; i < DUT_CHANNELS; i++) begin
			band_seen[i] = 1'b0;
			use_live[i] = 1'b0;
			issued_use[i] = 1'b0;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_report(DIRECTED[i].item, DIRECTED[i].pinned, DIRECTED[i].pin);

		// reset settings
		run_phase(RANDOM_PER_PHASE);
		// thresholds out of order, last one below the margin, zero hold, spare indexes poked
		configure(300, 100, 400, 20, 63, 0, 1'b1);
		run_phase(RANDOM_PER_PHASE);
		// all thresholds at the bottom, no margin, longest hold
		configure(0, 0, 0, 0, 0, 65535, 1'b0);
		run_phase(RANDOM_PER_PHASE);
		// all thresholds at the top, widest margin, shortest nonzero hold
		configure(511, 511, 511, 511, 63, 1, 1'b0);
		run_phase(RANDOM_PER_PHASE);
		// anything goes
		configure($urandom_range(511), $urandom_range(511), $urandom_range(511),
			$urandom_range(511), $urandom_range(63), $urandom_range(65535), 1'b1);
		run_phase(RANDOM_PER_PHASE);
		// back to the reset values, written explicitly
		configure(48, 120, 144, 168, 6, 3000, 1'b0);
		run_phase(RANDOM_PER_PHASE);

		drain();
		if (mismatch_count == 0 && pending_displays.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
